// File: rtl/tlpp_pkg.sv
// Shared constants and the CORDIC arctangent table for the tilt level pixel plotter.
// No dependencies.
package tlpp_pkg;

    // Field widths of the sample and display write channels
    localparam int ACCEL_W = 16;
    localparam int BYTE_W  = 8;
    localparam int PAGE_W  = 3;
    localparam int COL_W   = 7;

    // CORDIC datapath widths (vector and angle accumulator)
    localparam int VEC_W     = 27;
    localparam int ACC_W     = 26;
    localparam int ATAN_W    = 22;
    localparam int ATAN_LEN  = 24;
    localparam int ROOT_STEPS = 24;

    // Angle constants, 2^-16 degree units and Q.6 degrees
    localparam logic signed [VEC_W-1:0] QUARTER_TURN = 27'sd5898674;
    localparam logic signed [VEC_W-1:0] DEG90_Q16    = 27'sd5898240;
    localparam logic signed [16:0]      DEG90_Q6     = 17'sd5760;
    localparam int                      HALF_TURN_Q6 = 11520;

    // round(atan(2^-i) * 57.3 * 65536)
    function automatic logic [ATAN_W-1:0] atan_unit(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949337;
            5'd1:    v = 22'd1741095;
            5'd2:    v = 22'd919947;
            5'd3:    v = 22'd466979;
            5'd4:    v = 22'd234396;
            5'd5:    v = 22'd117312;
            5'd6:    v = 22'd58670;
            5'd7:    v = 22'd29337;
            5'd8:    v = 22'd14669;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1834;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tlpp_sample_if.sv
// Valid/ready channel carrying one accelerometer sample item.
// Depends on tlpp_pkg.
interface tlpp_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [tlpp_pkg::ACCEL_W-1:0] accel_x;
    logic signed [tlpp_pkg::ACCEL_W-1:0] accel_y;
    logic signed [tlpp_pkg::ACCEL_W-1:0] accel_z;
    logic                                recenter;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output recenter, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input recenter, output ready);
endinterface

// File: rtl/tlpp_pixel_if.sv
// Valid/ready channel carrying one display page write item.
// Depends on tlpp_pkg.
interface tlpp_pixel_if;
    logic                               valid;
    logic                               ready;
    logic [tlpp_pkg::BYTE_W-1:0]        pixel_byte;
    logic [tlpp_pkg::PAGE_W-1:0]        page_index;
    logic [tlpp_pkg::COL_W-1:0]         column_index;
    logic                               last_write;

    modport source (output valid, output pixel_byte, output page_index,
                    output column_index, output last_write, input ready);
    modport sink   (input valid, input pixel_byte, input page_index,
                    input column_index, input last_write, output ready);
endinterface

// File: rtl/tlpp_front.sv
// Front end: accepts a sample, runs isqrt, two CORDIC atan2 passes and the pixel
// mapping, then pushes the (row, column) pair into the queue. Depends on tlpp_pkg.
module tlpp_front #(
    parameter int DISPLAY_ROWS = 64,
    parameter int DISPLAY_COLS = 128,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tlpp_sample_if.sink           sample,
    output logic                  push,
    output logic [$clog2(DISPLAY_ROWS)+$clog2(DISPLAY_COLS)-1:0] push_data,
    input  logic                  full
);
    localparam int RW    = $clog2(DISPLAY_ROWS);
    localparam int CW    = $clog2(DISPLAY_COLS);
    localparam int DW    = (RW > CW) ? RW : CW;
    localparam int NSTEP = (CORDIC_STEPS < tlpp_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                               : tlpp_pkg::ATAN_LEN;
    localparam int DMAX  = (DISPLAY_ROWS > DISPLAY_COLS) ? DISPLAY_ROWS : DISPLAY_COLS;
    localparam int MW    = 19 + $clog2(DMAX + 1);
    localparam int REM_W = DW + 14;
    localparam int NW    = REM_W - 8;
    localparam int PW    = NW + 15;
    localparam int VW    = tlpp_pkg::VEC_W;
    localparam int AW    = tlpp_pkg::ACC_W;

    localparam logic signed [MW-1:0] ROWS_S  = MW'(DISPLAY_ROWS);
    localparam logic signed [MW-1:0] COLS_S  = MW'(DISPLAY_COLS);
    localparam logic signed [MW-1:0] ROW_LIM = MW'(DISPLAY_ROWS * tlpp_pkg::HALF_TURN_Q6);
    localparam logic signed [MW-1:0] COL_LIM = MW'(DISPLAY_COLS * tlpp_pkg::HALF_TURN_Q6);
    localparam logic signed [MW-1:0] ROUND_S = MW'(tlpp_pkg::HALF_TURN_Q6 / 2);
    // 11520 = 45 * 2^8; ceil(2^20 / 45) is exact for every in-range numerator
    localparam logic [14:0]          RECIP   = 15'd23302;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SQUARE = 10'b0000000010,
        S_SUM    = 10'b0000000100,
        S_ROOT   = 10'b0000001000,
        S_PITCH  = 10'b0000010000,
        S_ANGLE  = 10'b0000100000,
        S_SCALE  = 10'b0001000000,
        S_DIVSET = 10'b0010000000,
        S_DIVIDE = 10'b0100000000,
        S_PUSH   = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] acc;
    } vec_t;

    // Quarter-turn pre-rotation when the second operand is negative
    function automatic vec_t cordic_load(input logic signed [VW-1:0] a,
                                         input logic signed [VW-1:0] b);
        vec_t v;
        if (b < 0) begin
            if (a >= 0) begin
                v.x   = a;
                v.y   = -b;
                v.acc = AW'(tlpp_pkg::QUARTER_TURN);
            end
            else begin
                v.x   = -a;
                v.y   = b;
                v.acc = -AW'(tlpp_pkg::QUARTER_TURN);
            end
        end
        else begin
            v.x   = b;
            v.y   = a;
            v.acc = '0;
        end
        return v;
    endfunction

    state_t state_reg, state_next;

    logic signed [tlpp_pkg::ACCEL_W-1:0] x_reg, y_reg, z_reg;
    logic                                rc_reg;
    logic [31:0]                         sqy_reg, sqz_reg;
    logic [47:0]                         rad_reg, res_reg, bit_reg;
    logic [4:0]                          root_cnt_reg;
    logic signed [VW-1:0]                cx_reg, cy_reg;
    logic signed [AW-1:0]                cacc_reg, roll_acc_reg;
    logic [4:0]                          ci_reg;
    logic signed [16:0]                  roll_raw_reg, pitch_raw_reg;
    logic signed [17:0]                  roll_reg, pitch_reg;
    logic signed [15:0]                  roll_off_reg, pitch_off_reg;
    logic signed [MW-1:0]                num_row_reg, num_col_reg;
    logic [REM_W-1:0]                    rem_r_reg, rem_c_reg;
    logic [DW-1:0]                       q_r_reg, q_c_reg;
    logic                                sat_r_reg, sat_c_reg;

    logic                 accept;
    vec_t                 roll_load, pitch_load;
    logic signed [VW-1:0] dx, dy;
    logic signed [AW-1:0] au;
    logic                 cordic_run;
    logic [47:0]          trial, rad_step, res_step;
    logic signed [VW-1:0] v_roll, v_pitch;
    logic signed [16:0]   roll_raw_c, pitch_raw_c;
    logic signed [MW-1:0] dc;
    logic [PW-1:0]        prod_r, prod_c;
    logic [RW-1:0]        row_q;
    logic [CW-1:0]        col_q;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    // Vector loads for the roll and pitch passes
    assign roll_load  = cordic_load(VW'(sample.accel_y) <<< 8, VW'(sample.accel_z) <<< 8);
    assign pitch_load = cordic_load(-(VW'(x_reg) <<< 8), VW'({1'b0, res_step[23:0]}));

    // One CORDIC vectoring iteration
    assign dx = cy_reg >>> ci_reg;
    assign dy = cx_reg >>> ci_reg;
    assign au = AW'(tlpp_pkg::atan_unit(ci_reg));
    assign cordic_run = (ci_reg < 5'(NSTEP)) &&
                        ((state_reg == S_SQUARE) || (state_reg == S_SUM) ||
                         (state_reg == S_ROOT) || (state_reg == S_PITCH));

    // One digit of the integer square root
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (rad_reg >= trial)
        begin
            rad_step = rad_reg - trial;
            res_step = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rad_step = rad_reg;
            res_step = res_reg >> 1;
        end
    end

    // Angles rounded to Q.6
    assign v_roll      = tlpp_pkg::DEG90_Q16 - VW'(roll_acc_reg);
    assign v_pitch     = tlpp_pkg::DEG90_Q16 + VW'(cacc_reg);
    assign roll_raw_c  = 17'((v_roll + VW'(512)) >>> 10);
    assign pitch_raw_c = 17'((v_pitch + VW'(512)) >>> 10);

    assign dc = num_col_reg + ROUND_S;

    // Divide by 11520: drop 8 low bits, then multiply by the reciprocal of 45
    assign prod_r = PW'(rem_r_reg[REM_W-1:8]) * PW'(RECIP);
    assign prod_c = PW'(rem_c_reg[REM_W-1:8]) * PW'(RECIP);

    assign row_q     = sat_r_reg ? RW'(DISPLAY_ROWS - 1) : q_r_reg[RW-1:0];
    assign col_q     = sat_c_reg ? CW'(DISPLAY_COLS - 1) : q_c_reg[CW-1:0];
    assign push      = (state_reg == S_PUSH) && !full;
    assign push_data = {row_q, col_q};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_SQUARE;
            S_SQUARE: state_next = S_SUM;
            S_SUM:    state_next = S_ROOT;
            S_ROOT:   if (root_cnt_reg == 5'(tlpp_pkg::ROOT_STEPS - 1)) state_next = S_PITCH;
            S_PITCH:  if (ci_reg >= 5'(NSTEP - 1)) state_next = S_ANGLE;
            S_ANGLE:  state_next = S_SCALE;
            S_SCALE:  state_next = S_DIVSET;
            S_DIVSET: state_next = S_DIVIDE;
            S_DIVIDE: state_next = S_PUSH;
            S_PUSH:   if (!full) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            roll_off_reg  <= '0;
            pitch_off_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIVSET && rc_reg)
            begin
                roll_off_reg  <= 16'(roll_raw_reg - tlpp_pkg::DEG90_Q6);
                pitch_off_reg <= 16'(pitch_raw_reg - tlpp_pkg::DEG90_Q6);
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample.accel_x;
            y_reg    <= sample.accel_y;
            z_reg    <= sample.accel_z;
            rc_reg   <= sample.recenter;
            cx_reg   <= roll_load.x;
            cy_reg   <= roll_load.y;
            cacc_reg <= roll_load.acc;
            ci_reg   <= '0;
        end
        else if (state_reg == S_ROOT && root_cnt_reg == 5'(tlpp_pkg::ROOT_STEPS - 1))
        begin
            roll_acc_reg <= cacc_reg;
            cx_reg       <= pitch_load.x;
            cy_reg       <= pitch_load.y;
            cacc_reg     <= pitch_load.acc;
            ci_reg       <= '0;
        end
        else if (cordic_run)
        begin
            if (!cy_reg[VW-1])
            begin
                cx_reg   <= cx_reg + dx;
                cy_reg   <= cy_reg - dy;
                cacc_reg <= cacc_reg + au;
            end
            else
            begin
                cx_reg   <= cx_reg - dx;
                cy_reg   <= cy_reg + dy;
                cacc_reg <= cacc_reg - au;
            end
            ci_reg <= ci_reg + 5'd1;
        end

        case (state_reg)
            S_SQUARE:
            begin
                sqy_reg <= 32'(y_reg) * 32'(y_reg);
                sqz_reg <= 32'(z_reg) * 32'(z_reg);
            end
            S_SUM:
            begin
                rad_reg      <= {sqy_reg + sqz_reg, 16'h0000};
                res_reg      <= '0;
                bit_reg      <= 48'h1 << 46;
                root_cnt_reg <= '0;
            end
            S_ROOT:
            begin
                rad_reg      <= rad_step;
                res_reg      <= res_step;
                bit_reg      <= bit_reg >> 2;
                root_cnt_reg <= root_cnt_reg + 5'd1;
            end
            S_ANGLE:
            begin
                roll_raw_reg  <= roll_raw_c;
                pitch_raw_reg <= pitch_raw_c;
                roll_reg      <= 18'(roll_raw_c) - 18'(roll_off_reg);
                pitch_reg     <= 18'(pitch_raw_c) - 18'(pitch_off_reg);
            end
            S_SCALE:
            begin
                num_row_reg <= MW'(pitch_reg) * ROWS_S;
                num_col_reg <= MW'(roll_reg) * COLS_S;
            end
            S_DIVSET:
            begin
                sat_r_reg <= !num_row_reg[MW-1] && (num_row_reg >= ROW_LIM);
                sat_c_reg <= !num_col_reg[MW-1] && (dc >= COL_LIM);
                if (num_row_reg[MW-1] || num_row_reg >= ROW_LIM)
                    rem_r_reg <= '0;
                else
                    rem_r_reg <= REM_W'(num_row_reg);
                if (num_col_reg[MW-1] || dc >= COL_LIM)
                    rem_c_reg <= '0;
                else
                    rem_c_reg <= REM_W'(dc);
            end
            S_DIVIDE:
            begin
                q_r_reg <= prod_r[DW+19:20];
                q_c_reg <= prod_c[DW+19:20];
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/tlpp_fifo.sv
// Two-entry queue between the angle front end and the write sequencer.
// No package dependencies.
module tlpp_fifo #(
    parameter int WIDTH = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/tlpp_back.sv
// Back end: turns each queued pixel into an erase write if it moved, then dot and center
// page writes (merged into one when they share a page and column). Depends on tlpp_pkg.
module tlpp_back #(
    parameter int DISPLAY_ROWS = 64,
    parameter int DISPLAY_COLS = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [$clog2(DISPLAY_ROWS)+$clog2(DISPLAY_COLS)-1:0] head,
    input  logic         empty,
    output logic         pop,
    tlpp_pixel_if.source pixel
);
    localparam int RW = $clog2(DISPLAY_ROWS);
    localparam int CW = $clog2(DISPLAY_COLS);
    localparam logic [RW-1:0] CROW = RW'(DISPLAY_ROWS / 2);
    localparam logic [CW-1:0] CCOL = CW'(DISPLAY_COLS / 2);

    typedef enum logic [2:0] {
        ST_ERASE  = 3'b001,
        ST_DOT    = 3'b010,
        ST_CENTER = 3'b100
    } step_t;

    step_t step_reg, step_next, cur;

    logic [RW-1:0] prev_row_reg, row_h;
    logic [CW-1:0] prev_col_reg, col_h;
    logic          valid_reg, last_reg;
    logic [tlpp_pkg::BYTE_W-1:0] byte_reg, w_byte;
    logic [tlpp_pkg::PAGE_W-1:0] page_reg, w_page;
    logic [tlpp_pkg::COL_W-1:0]  col_reg, w_col;
    logic          w_last, moved, merged, go;

    assign row_h  = head[RW+CW-1:CW];
    assign col_h  = head[CW-1:0];
    assign moved  = (row_h != prev_row_reg) || (col_h != prev_col_reg);
    assign merged = (col_h == CCOL) && ((row_h >> 3) == (CROW >> 3));
    assign go     = !empty && (!valid_reg || pixel.ready);
    assign cur    = (step_reg == ST_ERASE && !moved) ? ST_DOT : step_reg;

    // Select the write for the current step
    always_comb
    begin
        w_byte    = '0;
        w_page    = '0;
        w_col     = '0;
        w_last    = 1'b0;
        step_next = step_reg;
        pop       = 1'b0;
        unique case (cur)
            ST_ERASE:
            begin
                w_page    = tlpp_pkg::PAGE_W'(prev_row_reg >> 3);
                w_col     = tlpp_pkg::COL_W'(prev_col_reg);
                step_next = ST_DOT;
            end
            ST_DOT:
            begin
                if (merged)
                begin
                    w_byte    = (8'd1 << row_h[2:0]) | (8'd1 << CROW[2:0]);
                    w_page    = tlpp_pkg::PAGE_W'(CROW >> 3);
                    w_col     = tlpp_pkg::COL_W'(CCOL);
                    w_last    = 1'b1;
                    step_next = ST_ERASE;
                    pop       = go;
                end
                else
                begin
                    w_byte    = 8'd1 << row_h[2:0];
                    w_page    = tlpp_pkg::PAGE_W'(row_h >> 3);
                    w_col     = tlpp_pkg::COL_W'(col_h);
                    step_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                w_byte    = 8'd1 << CROW[2:0];
                w_page    = tlpp_pkg::PAGE_W'(CROW >> 3);
                w_col     = tlpp_pkg::COL_W'(CCOL);
                w_last    = 1'b1;
                step_next = ST_ERASE;
                pop       = go;
            end
            default: ;
        endcase
    end

    assign pixel.valid        = valid_reg;
    assign pixel.pixel_byte   = byte_reg;
    assign pixel.page_index   = page_reg;
    assign pixel.column_index = col_reg;
    assign pixel.last_write   = last_reg;

    // Sequencer state, previous dot and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_ERASE;
            prev_row_reg <= '0;
            prev_col_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else if (go)
        begin
            step_reg  <= step_next;
            valid_reg <= 1'b1;
            if (pop)
            begin
                prev_row_reg <= row_h;
                prev_col_reg <= col_h;
            end
        end
        else if (pixel.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            byte_reg <= w_byte;
            page_reg <= w_page;
            col_reg  <= w_col;
            last_reg <= w_last;
        end
    end

endmodule

// File: rtl/tilt_level_pixel_plotter_top.sv
// Top level of the tilt level pixel plotter: front end, queue and write sequencer.
// Depends on tlpp_pkg, tlpp_sample_if, tlpp_pixel_if, tlpp_front, tlpp_fifo, tlpp_back.
//
// Usage:
//   sample: one accelerometer item (accel_x, accel_y, accel_z, recenter) per
//           valid/ready handshake. Roll and pitch are found by integer square
//           root and two CORDIC atan2 passes and mapped to a display pixel.
//   pixel:  one to three page write items per sample (erase the old dot if it
//           moved, draw the new dot, draw the center dot, or one merged write);
//           last_write marks the final one.
//   Timing: the front end takes one sample at a time; how long it stays busy
//           is set by the 24-step square root, the pitch CORDIC pass and any
//           wait on a full queue. The first write then passes the queue and the
//           output register; the rest follow one per cycle while pixel.ready holds.
//   Stall:  a two-entry queue and the output register let the front end take
//           the next sample while writes wait on pixel.ready.
//   Reset:  offsets and previous dot clear to zero, all channels go idle.
module tilt_level_pixel_plotter_top #(
    parameter int DISPLAY_ROWS = 64,
    parameter int DISPLAY_COLS = 128,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    tlpp_sample_if.sink  sample,
    tlpp_pixel_if.source pixel
);
    localparam int EW = $clog2(DISPLAY_ROWS) + $clog2(DISPLAY_COLS);

    logic          push, full, pop, empty;
    logic [EW-1:0] push_data, head;

    // Angle and pixel computation
    tlpp_front #(
        .DISPLAY_ROWS (DISPLAY_ROWS),
        .DISPLAY_COLS (DISPLAY_COLS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Pixel queue
    tlpp_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Display write sequencer
    tlpp_back #(
        .DISPLAY_ROWS (DISPLAY_ROWS),
        .DISPLAY_COLS (DISPLAY_COLS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .pixel (pixel)
    );

endmodule

// File: sim/tb_tilt_level_pixel_plotter_top.sv
// Testbench for tilt_level_pixel_plotter_top: random and directed samples, with
// page writes predicted by a bit-exact tilt-to-pixel model and checked in order.
// Depends on tlpp_pkg, tlpp_sample_if, tlpp_pixel_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_tilt_level_pixel_plotter_top;

    localparam int ROWS  = 64;
    localparam int COLS  = 128;
    localparam int STEPS = 16;
    localparam int RANDOM_SAMPLES = 250;

    typedef struct packed {
        logic [tlpp_pkg::BYTE_W-1:0] pixel_byte;
        logic [tlpp_pkg::PAGE_W-1:0] page_index;
        logic [tlpp_pkg::COL_W-1:0]  column_index;
        logic                        last_write;
    } page_write_t;

    // Tilt-to-pixel predictor with the queue of page writes it expects
    class tilt_scoreboard;
        page_write_t    pending_writes[$];
        logic [15:0]    roll_trim, pitch_trim;
        int unsigned    last_row, last_col;
        int             fail_count;
        int             write_count;

        function new();
            roll_trim = 0; pitch_trim = 0; last_row = 0; last_col = 0;
            fail_count = 0; write_count = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint root_floor(longint v);
            longint r, b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        // Vectoring CORDIC angle of (b, a) in 2^-16 degree units
        function longint angle_of(longint a, longint b);
            longint xv, yv, acc, t, dx, dy;
            xv = b; yv = a; acc = 0;
            if (xv < 0)
            begin
                t = xv;
                if (yv >= 0)
                begin
                    xv = yv; yv = -t; acc = tlpp_pkg::QUARTER_TURN;
                end
                else
                begin
                    xv = -yv; yv = t; acc = -tlpp_pkg::QUARTER_TURN;
                end
            end
            for (int i = 0; i < STEPS; i++)
            begin
                dx = floor_shift(yv, i);
                dy = floor_shift(xv, i);
                if (yv >= 0)
                begin
                    xv += dx; yv -= dy; acc += tlpp_pkg::atan_unit(i[4:0]);
                end
                else
                begin
                    xv -= dx; yv += dy; acc -= tlpp_pkg::atan_unit(i[4:0]);
                end
            end
            return acc;
        endfunction

        function void push_write(int b, int pg, int c, bit lst);
            page_write_t w;
            w.pixel_byte = b[7:0];
            w.page_index = pg[2:0];
            w.column_index = c[6:0];
            w.last_write = lst;
            pending_writes.push_back(w);
        endfunction

        function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az, logic rc);
            longint x, y, z, mag, roll_raw, pitch_raw, roll, pitch, num, r, c;
            int unsigned crow, ccol;
            x = ax; y = ay; z = az;
            crow = ROWS / 2; ccol = COLS / 2;
            mag = root_floor((y * y + z * z) * 65536);
            roll_raw = floor_shift(tlpp_pkg::DEG90_Q16 - angle_of(y * 256, z * 256) + 512,
                                   10);
            pitch_raw = floor_shift(tlpp_pkg::DEG90_Q16 + angle_of(-x * 256, mag) + 512, 10);
            roll = roll_raw - longint'($signed(roll_trim));
            pitch = pitch_raw - longint'($signed(pitch_trim));
            num = pitch * ROWS;
            r = num / tlpp_pkg::HALF_TURN_Q6;
            if (r < 0) r = 0;
            if (r > ROWS - 1) r = ROWS - 1;
            num = roll * COLS;
            if (num >= 0)
                c = (num + tlpp_pkg::HALF_TURN_Q6 / 2) / tlpp_pkg::HALF_TURN_Q6;
            else
                c = -((-num + tlpp_pkg::HALF_TURN_Q6 / 2) / tlpp_pkg::HALF_TURN_Q6);
            if (c < 0) c = 0;
            if (c > COLS - 1) c = COLS - 1;
            // erase the old dot only if it moved
            if (r != last_row || c != last_col)
                push_write(0, last_row >> 3, last_col, 0);
            if (c == ccol && (r >> 3) == (crow >> 3))
                push_write((1 << (r & 7)) | (1 << (crow & 7)), crow >> 3, ccol, 1);
            else
            begin
                push_write(1 << (r & 7), r >> 3, c, 0);
                push_write(1 << (crow & 7), crow >> 3, ccol, 1);
            end
            last_row = 32'(r);
            last_col = 32'(c);
            if (rc)
            begin
                roll_trim = 16'(roll_raw - tlpp_pkg::DEG90_Q6);
                pitch_trim = 16'(pitch_raw - tlpp_pkg::DEG90_Q6);
            end
        endfunction

        function void check_write(page_write_t got);
            page_write_t exp_w;
            write_count++;
            if (pending_writes.size() == 0)
            begin
                $error("unexpected page write %p", got);
                fail_count++;
                return;
            end
            exp_w = pending_writes.pop_front();
            if (got.pixel_byte !== exp_w.pixel_byte)
            begin
                $error("pixel_byte exp %0h got %0h", exp_w.pixel_byte, got.pixel_byte);
                fail_count++;
            end
            if (got.page_index !== exp_w.page_index)
            begin
                $error("page_index exp %0d got %0d", exp_w.page_index, got.page_index);
                fail_count++;
            end
            if (got.column_index !== exp_w.column_index)
            begin
                $error("column_index exp %0d got %0d", exp_w.column_index,
                       got.column_index);
                fail_count++;
            end
            if (got.last_write !== exp_w.last_write)
            begin
                $error("last_write exp %0b got %0b", exp_w.last_write, got.last_write);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm_phase;
    int   sample_count;
    tilt_scoreboard tracker;

    tlpp_sample_if sample();
    tlpp_pixel_if  pixel();

    tilt_level_pixel_plotter_top #(
        .DISPLAY_ROWS(ROWS),
        .DISPLAY_COLS(COLS),
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample.sink),
        .pixel(pixel.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one sample; random idle burst first unless in the calm phase
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic rc);
        if (!calm_phase && $urandom_range(0, 2) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        sample.valid <= 1'b1;
        sample.accel_x <= ax;
        sample.accel_y <= ay;
        sample.accel_z <= az;
        sample.recenter <= rc;
        do @(posedge clk); while (!sample.ready);
        tracker.note_sample(ax, ay, az, rc);
        sample_count++;
        @(negedge clk);
    endtask

    // Pose with z up: z = g, with x and y random in [-g, g]
    task automatic send_pose(logic rc);
        int g;
        g = $urandom_range(4000, 20000);
        send_sample($signed(16'($urandom_range(0, 2 * g) - g)),
                    $signed(16'($urandom_range(0, 2 * g) - g)),
                    16'(g), rc);
    endtask

    // Result sink with random stall bursts
    initial
    begin
        pixel.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                pixel.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            pixel.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel.valid && pixel.ready)
            tracker.check_write({pixel.pixel_byte, pixel.page_index,
                                 pixel.column_index, pixel.last_write});
    end

    initial
    begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        tracker = new();
        calm_phase = 1'b0;
        sample_count = 0;
        sample.valid = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        sample.recenter = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero vector, extremes, each quadrant, centre, recenter
        send_sample(0, 0, 0, 0);
        send_sample(0, 0, 0, 0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 0);
        send_sample(16'sh7fff, -16'sd32768, 16'sh7fff, 0);
        send_sample(-16'sd32768, 16'sh7fff, -16'sd32768, 0);
        send_sample(0, 0, 16384, 0);
        send_sample(0, 0, 16384, 0);
        send_sample(0, 0, -16384, 0);
        send_sample(0, 16384, 0, 0);
        send_sample(0, -16384, 0, 0);
        send_sample(16384, 0, 0, 0);
        send_sample(-16384, 0, 0, 0);
        send_sample(-1, -1, -1, 0);
        send_sample(1, 1, 1, 0);
        send_sample(3000, -2000, 16000, 1);
        send_sample(3000, -2000, 16000, 0);
        send_sample(0, 0, 16384, 0);
        send_sample(-16384, 16384, -16384, 1);
        send_sample(16384, -16384, 16384, 1);
        send_sample(0, 0, 16384, 1);
        send_sample(0, 0, 16384, 0);

        // Random: mostly near-level poses, some full-range noise
        for (int k = 0; k < RANDOM_SAMPLES; k++)
        begin
            if (k == RANDOM_SAMPLES - 40)
                calm_phase = 1'b1;
            if ($urandom_range(0, 3) == 0)
                send_sample($signed(16'($urandom)), $signed(16'($urandom)),
                            $signed(16'($urandom)), $urandom_range(0, 9) == 0);
            else
                send_pose($urandom_range(0, 14) == 0);
        end
        sample.valid <= 1'b0;

        wait_cycles = 0;
        while (tracker.pending_writes.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        $display("Sent %0d samples with recenters and idle bursts; checked %0d page writes.",
                 sample_count, tracker.write_count);
        if (tracker.fail_count == 0 && tracker.pending_writes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
